@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the vector stroke segment decoder.
// No dependencies; files that assert pull this in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define VSSD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// The expression must never be true outside reset.
`define VSSD_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define VSSD_ASSERT(lbl, clk, rst, prop)
`define VSSD_ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

@@ hw/rtl/vssd_pkg.sv @@
// Types and constants of the vector stroke segment decoder.
// No dependencies; used by the output channel interface and the top level.
package vssd_pkg;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_WIDE_COORDS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_Y_SHIFT     = 1'd1;

  localparam logic [7:0]  PEN_UP_BYTE = 8'h80;
  localparam logic [15:0] PEN_UP_WORD = 16'h8000;

  typedef logic signed [15:0] coord_t;

  // Position inside a point. Narrow mode tests only for PH_DX_LO (expecting dx)
  // and treats any other phase as expecting dy.
  typedef enum logic [1:0] {
    PH_DX_LO = 2'd0,
    PH_DX_HI = 2'd1,
    PH_DY_LO = 2'd2,
    PH_DY_HI = 2'd3
  } phase_t;

endpackage

@@ hw/rtl/vssd_in_if.sv @@
// Input channel of the vector stroke segment decoder: one stroke byte per transfer.
// No dependencies.
interface vssd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stroke_byte;
  logic       glyph_first;

  modport source (output valid, output stroke_byte, output glyph_first, input ready);
  modport sink   (input valid, input stroke_byte, input glyph_first, output ready);
endinterface

@@ hw/rtl/vssd_out_if.sv @@
// Output channel of the vector stroke segment decoder: one line segment per transfer.
// Depends on vssd_pkg.
interface vssd_out_if;
  import vssd_pkg::*;

  logic   valid;
  logic   ready;
  coord_t from_x;
  coord_t from_y;
  coord_t to_x;
  coord_t to_y;

  modport source (output valid, output from_x, output from_y, output to_x, output to_y,
                  input ready);
  modport sink   (input valid, input from_x, input from_y, input to_x, input to_y,
                  output ready);
endinterface

@@ hw/rtl/vector_stroke_segment_decoder_unit.sv @@
// Top level of the vector stroke segment decoder: byte parser, pen state, segment register.
// Depends on vssd_pkg, vssd_in_if, vssd_out_if and assert_macros.svh.
//
//   channel   direction  payload                          transfer when
//   in_ch     in         stroke_byte[8], glyph_first[1]   valid & ready
//   out_ch    out        from_x, from_y, to_x, to_y [16]  valid & ready
//   cfg       in         cfg_index[1], cfg_data[16]       cfg_wr_en
//
// One byte is taken per cycle while the input is not stalled; a segment appears in
// the output register in the cycle after the byte that completes its point. The input is
// stalled only while a segment sits in the output register and the sink does not take it.
// Reset (rst, synchronous) clears configuration, pen state and the output valid.
`include "assert_macros.svh"

module vector_stroke_segment_decoder_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [vssd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vssd_pkg::CFG_DATA_W-1:0]  cfg_data,
  vssd_in_if.sink                          in_ch,
  vssd_out_if.source                       out_ch
);
  import vssd_pkg::*;

  // Configuration.
  logic        wide_coords;
  logic [15:0] y_shift;

  // Pen and parser state.
  logic [15:0] pos_x, pos_y, prev_x, prev_y, held_dx;
  logic [7:0]  held_low_byte;
  logic        pen_is_down;
  phase_t      field_phase;

  logic [15:0] pos_x_next, pos_y_next, prev_x_next, prev_y_next, held_dx_next;
  logic [7:0]  held_low_byte_next;
  logic        pen_is_down_next;
  phase_t      field_phase_next;

  // Output register.
  logic        out_valid;
  logic [15:0] seg_from_x, seg_from_y, seg_to_x, seg_to_y;

  // Working values.
  logic [15:0] eff_pos_x, eff_pos_y, eff_prev_x, eff_prev_y, eff_held_dx;
  logic [7:0]  eff_held_low;
  logic        eff_pen;
  phase_t      eff_phase;
  logic [15:0] word, byte_sext, dy, sum_x, sum_y, cur_y;
  logic        apply, emit, in_fire;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_coords <= 1'b0;
      y_shift     <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WIDE_COORDS: wide_coords <= cfg_data[0];
        CFG_Y_SHIFT:     y_shift     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // A glyph start clears the pen state before its byte is used.
  always_comb begin
    if (in_ch.glyph_first) begin
      eff_pos_x    = '0;
      eff_pos_y    = '0;
      eff_prev_x   = '0;
      eff_prev_y   = '0;
      eff_held_dx  = '0;
      eff_held_low = '0;
      eff_pen      = 1'b0;
      eff_phase    = PH_DX_LO;
    end else begin
      eff_pos_x    = pos_x;
      eff_pos_y    = pos_y;
      eff_prev_x   = prev_x;
      eff_prev_y   = prev_y;
      eff_held_dx  = held_dx;
      eff_held_low = held_low_byte;
      eff_pen      = pen_is_down;
      eff_phase    = field_phase;
    end
  end

  assign word      = {in_ch.stroke_byte, eff_held_low};
  assign byte_sext = {{8{in_ch.stroke_byte[7]}}, in_ch.stroke_byte};
  assign dy        = wide_coords ? word : byte_sext;
  assign sum_x     = eff_pos_x + eff_held_dx;
  assign sum_y     = eff_pos_y + dy;
  assign cur_y     = sum_y + y_shift;

  always_comb begin
    pos_x_next         = eff_pos_x;
    pos_y_next         = eff_pos_y;
    prev_x_next        = eff_prev_x;
    prev_y_next        = eff_prev_y;
    held_dx_next       = eff_held_dx;
    held_low_byte_next = eff_held_low;
    pen_is_down_next   = eff_pen;
    field_phase_next   = eff_phase;
    apply              = 1'b0;

    if (wide_coords) begin
      unique case (eff_phase)
        PH_DX_LO: begin
          held_low_byte_next = in_ch.stroke_byte;
          field_phase_next   = PH_DX_HI;
        end
        PH_DX_HI: begin
          if (word == PEN_UP_WORD) begin
            pen_is_down_next = 1'b0;
            field_phase_next = PH_DX_LO;
          end else begin
            held_dx_next     = word;
            field_phase_next = PH_DY_LO;
          end
        end
        PH_DY_LO: begin
          held_low_byte_next = in_ch.stroke_byte;
          field_phase_next   = PH_DY_HI;
        end
        PH_DY_HI: begin
          field_phase_next = PH_DX_LO;
          apply            = 1'b1;
        end
        default: ;
      endcase
    end else if (eff_phase == PH_DX_LO) begin
      if (in_ch.stroke_byte == PEN_UP_BYTE) begin
        pen_is_down_next = 1'b0;
      end else begin
        held_dx_next     = byte_sext;
        field_phase_next = PH_DX_HI;
      end
    end else begin
      field_phase_next = PH_DX_LO;
      apply            = 1'b1;
    end

    if (apply) begin
      pos_x_next       = sum_x;
      pos_y_next       = sum_y;
      prev_x_next      = sum_x;
      prev_y_next      = cur_y;
      pen_is_down_next = 1'b1;
    end
  end

  assign emit = apply && eff_pen;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x         <= '0;
      pos_y         <= '0;
      prev_x        <= '0;
      prev_y        <= '0;
      held_dx       <= '0;
      held_low_byte <= '0;
      pen_is_down   <= 1'b0;
      field_phase   <= PH_DX_LO;
    end else if (in_fire) begin
      pos_x         <= pos_x_next;
      pos_y         <= pos_y_next;
      prev_x        <= prev_x_next;
      prev_y        <= prev_y_next;
      held_dx       <= held_dx_next;
      held_low_byte <= held_low_byte_next;
      pen_is_down   <= pen_is_down_next;
      field_phase   <= field_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= in_fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      seg_from_x <= eff_prev_x;
      seg_from_y <= eff_prev_y;
      seg_to_x   <= sum_x;
      seg_to_y   <= cur_y;
    end
  end

  assign out_ch.valid  = out_valid;
  assign out_ch.from_x = seg_from_x;
  assign out_ch.from_y = seg_from_y;
  assign out_ch.to_x   = seg_to_x;
  assign out_ch.to_y   = seg_to_y;

  // A glyph start puts the pen up, so its byte can never finish a segment.
  `VSSD_ASSERT(a_glyph_first_no_segment, clk, rst, in_fire && in_ch.glyph_first |=> !out_valid)
  // A waiting segment always ends at the stored last point with the pen down.
  `VSSD_ASSERT(a_segment_ends_at_prev, clk, rst,
    out_valid |-> pen_is_down && seg_to_x == prev_x && seg_to_y == prev_y)
  // The narrow pen-up marker in the dx slot lifts the pen.
  `VSSD_ASSERT(a_narrow_pen_up, clk, rst,
    in_fire && !wide_coords && eff_phase == PH_DX_LO && in_ch.stroke_byte == PEN_UP_BYTE
    |=> !pen_is_down)

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for vector_stroke_segment_decoder_unit: drives stroke bytes,
// predicts segments with its own pen-state tracker and checks every output transfer.
// Depends on vssd_pkg, vssd_in_if, vssd_out_if and the RTL of the unit.
`timescale 1ns / 100ps

module tb_top;
  import vssd_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       first;
  } stroke_item_t;

  typedef struct packed {
    coord_t fx;
    coord_t fy;
    coord_t tx;
    coord_t ty;
  } segment_t;

  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned PHASE_BYTES  = 115;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  vssd_in_if  in_ch();
  vssd_out_if out_ch();

  vector_stroke_segment_decoder_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  stroke_item_t pending[$];
  segment_t     seg_expected[$];

  int unsigned bytes_queued;
  int unsigned bytes_taken;
  int unsigned segs_checked;
  int unsigned pen_lifts;
  int unsigned glyphs_sent;
  int unsigned errors;
  bit          steady;

  // Shadow of the configuration and of the pen state.
  logic        cfg_wide;
  logic [15:0] cfg_shift;
  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic        pen_down;
  logic [15:0] last_x;
  logic [15:0] last_y;
  logic [7:0]  low_hold;
  logic [15:0] dx_hold;
  phase_t      ph;

  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned ready_hold;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("FAIL vector_stroke_segment_decoder_unit");
    $finish;
  end

  task automatic clear_pen();
    pen_x    = '0;
    pen_y    = '0;
    pen_down = 1'b0;
    last_x   = '0;
    last_y   = '0;
    low_hold = '0;
    dx_hold  = '0;
    ph       = PH_DX_LO;
  endtask

  // Advances the shadow pen state by one stroke byte and queues the segment it completes.
  task automatic decode_stroke_byte(input logic [7:0] b, input logic first);
    logic [15:0] word;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] cur_y;
    logic        done;
    segment_t    seg;
    if (first) clear_pen();
    done = 1'b0;
    dx   = '0;
    dy   = '0;
    if (cfg_wide) begin
      case (ph)
        PH_DX_LO: begin
          low_hold = b;
          ph       = PH_DX_HI;
        end
        PH_DX_HI: begin
          word = {b, low_hold};
          if (word == PEN_UP_WORD) begin
            pen_down = 1'b0;
            ph       = PH_DX_LO;
            pen_lifts++;
          end else begin
            dx_hold = word;
            ph      = PH_DY_LO;
          end
        end
        PH_DY_LO: begin
          low_hold = b;
          ph       = PH_DY_HI;
        end
        default: begin
          dx   = dx_hold;
          dy   = {b, low_hold};
          ph   = PH_DX_LO;
          done = 1'b1;
        end
      endcase
    end else if (ph == PH_DX_LO) begin
      if (b == PEN_UP_BYTE) begin
        pen_down = 1'b0;
        pen_lifts++;
      end else begin
        dx_hold = {{8{b[7]}}, b};
        ph      = PH_DX_HI;
      end
    end else begin
      // Any nonzero phase in narrow mode takes the byte as dy.
      dx   = dx_hold;
      dy   = {{8{b[7]}}, b};
      ph   = PH_DX_LO;
      done = 1'b1;
    end
    if (done) begin
      pen_x = pen_x + dx;
      pen_y = pen_y + dy;
      cur_y = pen_y + cfg_shift;
      if (pen_down) begin
        seg.fx = last_x;
        seg.fy = last_y;
        seg.tx = pen_x;
        seg.ty = cur_y;
        seg_expected.insert(seg_expected.size(), seg);
      end
      last_x   = pen_x;
      last_y   = cur_y;
      pen_down = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input coord_t got, input coord_t want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic first);
    stroke_item_t item;
    item.b     = b;
    item.first = first;
    pending.insert(pending.size(), item);
    bytes_queued++;
    if (first) glyphs_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_WIDE_COORDS) cfg_wide = data[0];
    else cfg_shift = data;
  endtask

  task automatic set_mode(input logic wide, input logic [15:0] shift);
    logic [15:0] junk;
    junk = 16'($urandom);
    // Upper bits of the mode write carry random data; only bit 0 counts.
    write_reg(CFG_WIDE_COORDS, {junk[15:1], wide});
    write_reg(CFG_Y_SHIFT, shift);
  endtask

  task automatic wait_idle();
    while (bytes_taken != bytes_queued || seg_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Pushes one delta of the current width; extremes come up now and then.
  task automatic push_delta(input logic first, input logic as_dx);
    logic [15:0] d;
    int unsigned pick;
    pick = $urandom_range(0, 7);
    case (pick)
      0: d = cfg_wide ? 16'h7FFF : 16'h007F;
      1: d = cfg_wide ? 16'h8001 : 16'h0081;
      2: d = cfg_wide ? 16'hFFFF : 16'h00FF;
      3: d = '0;
      default: d = 16'($urandom);
    endcase
    if (as_dx && cfg_wide && d == PEN_UP_WORD) d = 16'h8001;
    if (as_dx && !cfg_wide && d[7:0] == PEN_UP_BYTE) d[7:0] = 8'h81;
    if (!as_dx && pick == 1) d = cfg_wide ? PEN_UP_WORD : 16'h0080;
    push_byte(d[7:0], first);
    if (cfg_wide) push_byte(d[15:8], 1'b0);
  endtask

  task automatic push_glyph();
    int unsigned npts;
    int unsigned r;
    int unsigned k;
    logic        start;
    npts  = $urandom_range(1, 10);
    start = 1'b1;
    for (int unsigned i = 0; i < npts; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        if (cfg_wide) begin
          push_byte(PEN_UP_WORD[7:0], start);
          push_byte(PEN_UP_WORD[15:8], 1'b0);
        end else begin
          push_byte(PEN_UP_BYTE, start);
        end
      end else if (r < 14) begin
        push_byte(8'($urandom), start | ($urandom_range(0, 7) == 0));
      end else begin
        push_delta(start, 1'b1);
        push_delta(1'b0, 1'b0);
      end
      start = 1'b0;
    end
    // Sometimes leave a partial point for the next glyph start to drop.
    if ($urandom_range(0, 5) == 0) begin
      k = cfg_wide ? $urandom_range(1, 3) : 1;
      for (int unsigned j = 0; j < k; j++) push_byte(8'($urandom), 1'b0);
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    stroke_item_t item;
    if (rst) begin
      in_ch.valid       <= 1'b0;
      in_ch.stroke_byte <= '0;
      in_ch.glyph_first <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0 && !steady) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending.size() > 0) begin
        item = pending.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.stroke_byte <= item.b;
        in_ch.glyph_first <= item.first;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Every accepted byte runs through the shadow decoder.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      decode_stroke_byte(in_ch.stroke_byte, in_ch.glyph_first);
      bytes_taken++;
    end
  end

  // Receiver: alternating runs of ready and stall.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      ready_hold = 0;
    end else if (steady) begin
      out_ch.ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else if (out_ch.ready) begin
      out_ch.ready <= 1'b0;
      ready_hold = $urandom_range(0, 5);
    end else begin
      out_ch.ready <= 1'b1;
      ready_hold = $urandom_range(0, 11);
    end
  end

  always @(posedge clk) begin
    segment_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (seg_expected.size() == 0) begin
        report_mismatch("segment with none pending, from_x", out_ch.from_x, '0);
      end else begin
        want = seg_expected.pop_front();
        if (out_ch.from_x !== want.fx) report_mismatch("from_x", out_ch.from_x, want.fx);
        if (out_ch.from_y !== want.fy) report_mismatch("from_y", out_ch.from_y, want.fy);
        if (out_ch.to_x !== want.tx) report_mismatch("to_x", out_ch.to_x, want.tx);
        if (out_ch.to_y !== want.ty) report_mismatch("to_y", out_ch.to_y, want.ty);
        segs_checked++;
      end
    end
  end

  initial begin
    logic        modes[6];
    logic [15:0] shifts[6];
    int unsigned mark;
    in_ch.valid       = 1'b0;
    in_ch.stroke_byte = '0;
    in_ch.glyph_first = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    bytes_queued      = 0;
    bytes_taken       = 0;
    segs_checked      = 0;
    pen_lifts         = 0;
    glyphs_sent       = 0;
    errors            = 0;
    steady            = 1'b0;
    cfg_wide          = 1'b0;
    cfg_shift         = '0;
    clear_pen();
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Narrow mode: extremes, the marker as dy, a pen lift and a dropped partial point.
    set_mode(1'b0, 16'h0005);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h81, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(PEN_UP_BYTE, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_byte(8'h05, 1'b0);
    wait_idle();

    // Wide mode: 16-bit extremes with wrap, the word marker, then a point left at dy high.
    set_mode(1'b1, 16'h7FFF);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(PEN_UP_WORD[7:0], 1'b0);
    push_byte(PEN_UP_WORD[15:8], 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h56, 1'b0);
    wait_idle();

    // Switching to narrow mid-point finishes the point with the held dx.
    set_mode(1'b0, 16'h8000);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h01, 1'b0);
    wait_idle();

    modes[0] = 1'b0; shifts[0] = 16'h0000;
    modes[1] = 1'b1; shifts[1] = 16'($urandom);
    modes[2] = 1'b0; shifts[2] = 16'h8000;
    modes[3] = 1'b1; shifts[3] = 16'h7FFF;
    modes[4] = 1'b0; shifts[4] = 16'($urandom);
    modes[5] = 1'b1; shifts[5] = 16'hFFFF;
    for (int p = 0; p < 6; p++) begin
      set_mode(modes[p], shifts[p]);
      steady = (p == 3);
      mark   = bytes_queued;
      while (bytes_queued - mark < PHASE_BYTES) push_glyph();
      wait_idle();
      steady = 1'b0;
    end

    $display("run covered %0d stroke bytes over %0d glyph starts in both coordinate widths",
             bytes_taken, glyphs_sent);
    $display("%0d segments checked, %0d pen lifts seen", segs_checked, pen_lifts);
    if (errors == 0 && seg_expected.size() == 0) begin
      $display("PASS vector_stroke_segment_decoder_unit");
    end else begin
      $display("FAIL vector_stroke_segment_decoder_unit");
    end
    $finish;
  end

endmodule
